// ===== src/egb_pkg.sv =====
// Shared types and constants for the extended GCD (Bezout) block.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package egb_pkg;

    // Operand width and derived widths
    localparam int VALUE_BITS = 31;
    localparam int COEFF_BITS = VALUE_BITS + 1;
    localparam int CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    typedef logic [VALUE_BITS-1:0]        t_value;
    typedef logic signed [COEFF_BITS-1:0] t_coeff;
    typedef logic [CNT_BITS-1:0]          t_cnt;

    // Control from the sequencer to the divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status from the divider to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== src/egb_if.sv =====
// Request and result channel interfaces with valid/ready handshake.
// Depends on egb_pkg for the payload types.
`default_nettype none

interface egb_req_if import egb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value operand_a;
    t_value operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egb_res_if import egb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coeff coeff_s;
    t_coeff coeff_t;
    t_value divisor_result;
    logic   zero_divisor;

    modport source (output valid, output coeff_s, output coeff_t,
                    output divisor_result, output zero_divisor, input ready);
    modport sink   (input valid, input coeff_s, input coeff_t,
                    input divisor_result, input zero_divisor, output ready);
endinterface

`default_nettype wire

// ===== src/egb_divstep.sv =====
// Bit-serial restoring divider for one Euclid step, one quotient bit per cycle,
// accumulating quotient*s and quotient*t alongside. Depends on egb_pkg.
`default_nettype none

module egb_divstep import egb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_ctl i_ctl,
    input  wire t_value   i_dividend,
    input  wire t_value   i_divisor,
    input  wire t_coeff   i_s_cur,
    input  wire t_coeff   i_t_cur,
    output t_div_sts      o_sts,
    output t_value        o_rem,
    output t_coeff        o_acc_s,
    output t_coeff        o_acc_t
);

    logic   r_busy, n_busy;
    logic   r_done, n_done;
    t_cnt   r_cnt, n_cnt;
    t_value r_rem, n_rem;
    t_value r_quo, n_quo;
    t_coeff r_acc_s, n_acc_s;
    t_coeff r_acc_t, n_acc_t;

    logic [VALUE_BITS:0] trial;
    logic [VALUE_BITS:0] dvs_ext;
    logic [VALUE_BITS:0] diff;
    logic                ge;

    // Trial subtraction of the divisor from the shifted partial remainder
    always_comb begin
        trial   = {r_rem, r_quo[VALUE_BITS-1]};
        dvs_ext = {1'b0, i_divisor};
        diff    = trial - dvs_ext;
        ge      = (trial >= dvs_ext);
    end

    // Next state: load on start, else shift one bit while busy
    always_comb begin
        n_busy  = r_busy;
        n_done  = r_done;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_acc_s = r_acc_s;
        n_acc_t = r_acc_t;
        if (i_ctl.start) begin
            n_busy  = 1'b1;
            n_done  = 1'b0;
            n_cnt   = CNT_BITS'(VALUE_BITS - 1);
            n_rem   = '0;
            n_quo   = i_dividend;
            n_acc_s = '0;
            n_acc_t = '0;
        end else if (r_busy) begin
            n_rem   = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            n_quo   = {r_quo[VALUE_BITS-2:0], ge};
            n_acc_s = {r_acc_s[COEFF_BITS-2:0], 1'b0} + (ge ? i_s_cur : t_coeff'(0));
            n_acc_t = {r_acc_t[COEFF_BITS-2:0], 1'b0} + (ge ? i_t_cur : t_coeff'(0));
            n_cnt   = r_cnt - t_cnt'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_acc_s <= n_acc_s;
        r_acc_t <= n_acc_t;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;
    assign o_acc_s    = r_acc_s;
    assign o_acc_t    = r_acc_t;

    // Finished remainder is below the divisor it was taken against
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_ctl.start && i_divisor != '0) |-> (r_rem < i_divisor))
        else $error("remainder not below divisor");

    // Busy and done never overlap
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

    // A start sets the divider busy and clears done
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> (r_busy && !r_done))
        else $error("divider did not start");

endmodule

`default_nettype wire

// ===== src/extended_gcd_bezout.sv =====
// Extended Euclid: per request, the gcd and Bezout coefficients come from a chain of n
// Euclid divisions (at most 45 for 31-bit operands); a zero operand_b skips the divisions.
// Each division runs bit-serially through egb_divstep, one quotient bit per cycle.
// One request at a time; a new request is taken while the previous result waits.
// Synchronous active-low reset clears the sequencer and the result valid flag.
// Depends on egb_pkg, egb_if and egb_divstep.
`default_nettype none

module extended_gcd_bezout import egb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    egb_req_if.sink    i_req,
    egb_res_if.source  o_res
);

    t_state r_state, n_state;
    logic   r_start, n_start;
    t_value r_rem_prev, n_rem_prev;
    t_value r_rem_cur, n_rem_cur;
    t_coeff r_s_prev, n_s_prev;
    t_coeff r_s_cur, n_s_cur;
    t_coeff r_t_prev, n_t_prev;
    t_coeff r_t_cur, n_t_cur;
    logic   r_zero, n_zero;

    logic   r_out_valid, n_out_valid;
    t_coeff r_out_s, n_out_s;
    t_coeff r_out_t, n_out_t;
    t_value r_out_g, n_out_g;
    logic   r_out_z, n_out_z;

    t_div_ctl div_ctl;
    t_div_sts div_sts;
    t_value   div_rem;
    t_coeff   div_acc_s;
    t_coeff   div_acc_t;
    logic     req_acc;
    logic     res_acc;

    assign req_acc = i_req.valid && i_req.ready;
    assign res_acc = r_out_valid && o_res.ready;
    assign div_ctl.start = r_start;

    egb_divstep u_divstep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_rem_prev),
        .i_divisor  (r_rem_cur),
        .i_s_cur    (r_s_cur),
        .i_t_cur    (r_t_cur),
        .o_sts      (div_sts),
        .o_rem      (div_rem),
        .o_acc_s    (div_acc_s),
        .o_acc_t    (div_acc_t)
    );

    // Sequencer: load a request, iterate Euclid steps, hand over the result
    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_rem_prev  = r_rem_prev;
        n_rem_cur   = r_rem_cur;
        n_s_prev    = r_s_prev;
        n_s_cur     = r_s_cur;
        n_t_prev    = r_t_prev;
        n_t_cur     = r_t_cur;
        n_zero      = r_zero;
        n_out_valid = res_acc ? 1'b0 : r_out_valid;
        n_out_s     = r_out_s;
        n_out_t     = r_out_t;
        n_out_g     = r_out_g;
        n_out_z     = r_out_z;
        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.operand_b == '0) begin
                        // zero divisor: answer straight away
                        n_rem_cur = i_req.operand_a;
                        n_s_cur   = t_coeff'(1);
                        n_t_cur   = t_coeff'(0);
                        n_zero    = 1'b1;
                        n_state   = ST_FINISH;
                    end else begin
                        n_rem_prev = i_req.operand_a;
                        n_rem_cur  = i_req.operand_b;
                        n_s_prev   = t_coeff'(1);
                        n_s_cur    = t_coeff'(0);
                        n_t_prev   = t_coeff'(0);
                        n_t_cur    = t_coeff'(1);
                        n_zero     = 1'b0;
                        n_start    = 1'b1;
                        n_state    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_sts.done && !r_start) begin
                    if (div_rem == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_rem_prev = r_rem_cur;
                        n_rem_cur  = div_rem;
                        n_s_prev   = r_s_cur;
                        n_s_cur    = r_s_prev - div_acc_s;
                        n_t_prev   = r_t_cur;
                        n_t_cur    = r_t_prev - div_acc_t;
                        n_start    = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_s     = r_s_cur;
                    n_out_t     = r_t_cur;
                    n_out_g     = r_rem_cur;
                    n_out_z     = r_zero;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_rem_prev <= n_rem_prev;
        r_rem_cur  <= n_rem_cur;
        r_s_prev   <= n_s_prev;
        r_s_cur    <= n_s_cur;
        r_t_prev   <= n_t_prev;
        r_t_cur    <= n_t_cur;
        r_zero     <= n_zero;
        r_out_s    <= n_out_s;
        r_out_t    <= n_out_t;
        r_out_g    <= n_out_g;
        r_out_z    <= n_out_z;
    end

    assign i_req.ready          = (r_state == ST_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.coeff_s        = r_out_s;
    assign o_res.coeff_t        = r_out_t;
    assign o_res.divisor_result = r_out_g;
    assign o_res.zero_divisor   = r_out_z;

    // Divider only runs while stepping
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_start || div_sts.busy) |-> (r_state == ST_DIV))
        else $error("divider active outside a Euclid step");

    // Divisor never zero while stepping
    a_divisor_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem_cur != '0))
        else $error("zero divisor during Euclid step");

    // Zero-divisor result carries the identity coefficients
    a_zero_coeffs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_zero) |-> (r_s_cur == t_coeff'(1) && r_t_cur == '0))
        else $error("wrong coefficients for zero divisor");

endmodule

`default_nettype wire

// ===== dv/extended_gcd_bezout_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for extended_gcd_bezout: drives operand pairs, predicts
// the gcd and Bezout coefficients, and compares every result in order.
// Depends on egb_pkg, egb_if and the extended_gcd_bezout RTL.

module extended_gcd_bezout_test import egb_pkg::*; ();

    // Run shape
    localparam int RANDOM_ITEMS  = 1200;
    localparam int WAIT_MAX      = 17;
    localparam int HOLD_AT       = 150;      // results seen before the long hold-off
    localparam int HOLD_CYCLES   = 5000;
    localparam int DRAIN_CYCLES  = 2 + 45 * (VALUE_BITS + 1) + 20;
    localparam int CYCLE_LIMIT   = 8_000_000;

    typedef struct {
        t_value a;
        t_value b;
    } t_operands;

    typedef struct {
        t_coeff s;
        t_coeff t;
        t_value g;
        logic   zero_b;
    } t_bezout;

    logic i_clk;
    logic i_rst_n;

    egb_req_if req_if ();
    egb_res_if res_if ();

    extended_gcd_bezout DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_operands   gcd_requests[$];
    t_bezout     bezout_expected[$];
    int unsigned accepted_cnt;
    int unsigned checked_cnt;
    int unsigned zero_b_cnt;
    int unsigned divides_cnt;
    int unsigned mismatch_cnt;
    int unsigned req_gap;
    int unsigned res_stall;
    int unsigned hold_cnt;
    int unsigned cycle_cnt;
    logic        req_calm;
    logic        res_calm;
    logic        hold_done;

    // Euclid's division chain, coefficients kept modulo 2^64
    function automatic t_bezout bezout_predict(input t_value a, input t_value b);
        logic [63:0] r_old, r_now, r_nxt, quo;
        logic [63:0] s_old, s_now, s_nxt, t_old, t_now, t_nxt;
        t_bezout     res;
        if (b == '0) begin
            res.s      = t_coeff'(1);
            res.t      = '0;
            res.g      = a;
            res.zero_b = 1'b1;
            return res;
        end
        r_old = 64'(a);
        r_now = 64'(b);
        s_old = 64'd1;
        s_now = 64'd0;
        t_old = 64'd0;
        t_now = 64'd1;
        while (1) begin
            quo   = r_old / r_now;
            r_nxt = r_old - quo * r_now;
            if (r_nxt == 64'd0)
                break;
            s_nxt = s_old - quo * s_now;
            t_nxt = t_old - quo * t_now;
            r_old = r_now;
            r_now = r_nxt;
            s_old = s_now;
            s_now = s_nxt;
            t_old = t_now;
            t_now = t_nxt;
        end
        res.s      = s_now[COEFF_BITS-1:0];
        res.t      = t_now[COEFF_BITS-1:0];
        res.g      = r_now[VALUE_BITS-1:0];
        res.zero_b = 1'b0;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_cnt++;
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Reset and known levels on every input from time zero
    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        res_if.ready     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request driver: offers queued operand pairs with random gaps
    always @(posedge i_clk) begin : req_driver
        t_operands nxt;
        t_bezout   predicted;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_gap      <= 0;
            req_calm     <= 1'b0;
            accepted_cnt <= 0;
            zero_b_cnt   <= 0;
            divides_cnt  <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predicted = bezout_predict(req_if.operand_a, req_if.operand_b);
                bezout_expected.push_back(predicted);
                accepted_cnt <= accepted_cnt + 1;
                if (predicted.zero_b)
                    zero_b_cnt <= zero_b_cnt + 1;
                else if (predicted.g == req_if.operand_b)
                    divides_cnt <= divides_cnt + 1;
            end
            if (req_if.valid && !req_if.ready) begin
                // request still pending, hold it
            end else if (req_gap != 0) begin
                req_gap      <= req_gap - 1;
                req_if.valid <= 1'b0;
            end else if (gcd_requests.size() != 0) begin
                nxt = gcd_requests.pop_front();
                req_if.valid     <= 1'b1;
                req_if.operand_a <= nxt.a;
                req_if.operand_b <= nxt.b;
                if ($urandom_range(0, 39) == 0)
                    req_calm <= ~req_calm;
                req_gap <= req_calm ? 0 : $urandom_range(0, WAIT_MAX);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up onto its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && checked_cnt == HOLD_AT) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result monitor: random stalls, in-order comparison
    always @(posedge i_clk) begin : res_monitor
        t_bezout     want;
        int unsigned stall_nxt;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_stall    <= 0;
            res_calm     <= 1'b0;
            checked_cnt  <= 0;
        end else begin
            stall_nxt = res_stall;
            if (res_if.valid && res_if.ready) begin
                if (bezout_expected.size() == 0) begin
                    $display("%0t: result with nothing expected, s=%0d t=%0d gcd=%0d zero=%0b",
                             $time, res_if.coeff_s, res_if.coeff_t,
                             res_if.divisor_result, res_if.zero_divisor);
                    mismatch_cnt++;
                end else begin
                    want = bezout_expected.pop_front();
                    compare_field("coeff_s", want.s, res_if.coeff_s);
                    compare_field("coeff_t", want.t, res_if.coeff_t);
                    compare_field("divisor_result", want.g, res_if.divisor_result);
                    compare_field("zero_divisor", want.zero_b, res_if.zero_divisor);
                end
                checked_cnt <= checked_cnt + 1;
                if ($urandom_range(0, 39) == 0)
                    res_calm <= ~res_calm;
                stall_nxt = res_calm ? 0 : $urandom_range(0, WAIT_MAX);
            end else if (res_if.valid && res_stall != 0) begin
                stall_nxt = res_stall - 1;
            end
            res_stall    <= stall_nxt;
            res_if.ready <= (stall_nxt == 0) && (hold_cnt == 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: run timed out after %0d cycles", $time, cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        t_value      max_v;
        t_value      ra, rb;
        logic [63:0] fa, fb, fx;
        int unsigned kind, gf, total;
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        max_v        = '1;

        // Directed: zeros, extremes, divisibility, longest chain, bit patterns
        gcd_requests.push_back('{t_value'(0), t_value'(0)});
        gcd_requests.push_back('{max_v, t_value'(0)});
        gcd_requests.push_back('{t_value'(1), t_value'(0)});
        gcd_requests.push_back('{t_value'(0), t_value'(1)});
        gcd_requests.push_back('{t_value'(0), max_v});
        gcd_requests.push_back('{max_v, max_v});
        gcd_requests.push_back('{max_v, t_value'(1)});
        gcd_requests.push_back('{t_value'(1), max_v});
        gcd_requests.push_back('{t_value'(1), t_value'(1)});
        gcd_requests.push_back('{t_value'(12), t_value'(4)});
        gcd_requests.push_back('{t_value'(4), t_value'(12)});
        gcd_requests.push_back('{t_value'(240), t_value'(46)});
        gcd_requests.push_back('{t_value'(46), t_value'(240)});
        gcd_requests.push_back('{t_value'(6), t_value'(9)});
        gcd_requests.push_back('{t_value'(64'd1836311903), t_value'(64'd1134903170)});
        gcd_requests.push_back('{t_value'(64'd1134903170), t_value'(64'd1836311903)});
        gcd_requests.push_back('{max_v, max_v - 1'b1});
        gcd_requests.push_back('{t_value'(64'h5555_5555), t_value'(64'h2AAA_AAAA)});
        gcd_requests.push_back('{t_value'(64'h2AAA_AAAA), t_value'(64'h5555_5555)});
        gcd_requests.push_back('{t_value'(64'h4000_0000), t_value'(64'h2000_0000)});
        gcd_requests.push_back('{t_value'(64'h4000_0001), t_value'(3)});

        // Random: mostly full range, with zero divisors, exact multiples,
        // shared factors and Fibonacci neighbours for long chains
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                ra = t_value'($urandom());
                rb = t_value'($urandom());
            end else if (kind < 58) begin
                ra = t_value'($urandom_range(0, 255));
                rb = t_value'($urandom_range(0, 255));
            end else if (kind < 66) begin
                ra = ($urandom_range(0, 3) == 0) ? t_value'(0) : t_value'($urandom());
                rb = '0;
            end else if (kind < 76) begin
                rb = t_value'($urandom_range(1, 46340));
                ra = t_value'(64'(rb) * 64'($urandom_range(0, 46340)));
                if (rb == '0)
                    rb = t_value'(1);
            end else if (kind < 83) begin
                fa = 64'd1;
                fb = 64'd1;
                repeat ($urandom_range(1, 44)) begin
                    fx = fa + fb;
                    fa = fb;
                    fb = fx;
                end
                ra = t_value'(fb);
                rb = t_value'(fa);
            end else if (kind < 92) begin
                gf = $urandom_range(1, 1000);
                ra = t_value'(64'(gf) * 64'($urandom_range(0, 1 << 21)));
                rb = t_value'(64'(gf) * 64'($urandom_range(1, 1 << 21)));
            end else begin
                ra = t_value'($urandom());
                rb = ra - t_value'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 4) == 0)
                gcd_requests.push_back('{rb, ra});
            else
                gcd_requests.push_back('{ra, rb});
        end
        total = gcd_requests.size();

        // Wait for every request to be taken and every result to come back
        @(posedge i_clk);
        while (accepted_cnt != total)
            @(posedge i_clk);
        while (bezout_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d operand pairs: %0d with zero operand_b, %0d exact divisions.",
                 accepted_cnt, zero_b_cnt, divides_cnt);
        $display("Results checked: %0d, mismatches: %0d, cycles: %0d.",
                 checked_cnt, mismatch_cnt, cycle_cnt);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== extended_gcd_bezout.f =====
src/egb_pkg.sv
src/egb_if.sv
src/egb_divstep.sv
src/extended_gcd_bezout.sv
dv/extended_gcd_bezout_test.sv
